@@ hdl/tpg_pkg.sv @@
package tpg_pkg;

    // Fixed field widths of the segment description.
    localparam int ACCEL_W = 24;
    localparam int MIN_W   = 16;

    // Minimum start and end rate after reset, in steps per second.
    localparam logic [MIN_W-1:0] MIN_RATE_RESET = 16'd120;

endpackage

@@ hdl/trapezoid_profile_generator.sv @@
// An accepted segment passes through stages A, B and C, the dividers and the output register
// before the result strobe rises.
// Throughput: one segment per cycle; busy is always low and start may stay high.
// Each result is shown for one cycle with o_valid; the receiver cannot stall it.
// Reset (synchronous, active low) clears all valid bits, dropping segments in flight,
// and returns min_rate to 120 steps per second.
module trapezoid_profile_generator #(
    parameter int RATE_BITS     = 20,
    parameter int STEP_BITS     = 20,
    parameter int FRACTION_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_cfg_we,
    input  logic [tpg_pkg::MIN_W-1:0]     i_cfg_wdata,
    input  logic [RATE_BITS-1:0]          i_nominal_rate,
    input  logic [tpg_pkg::ACCEL_W-1:0]   i_accel_rate,
    input  logic [STEP_BITS-1:0]          i_total_steps,
    input  logic [FRACTION_BITS:0]        i_entry_factor,
    input  logic [FRACTION_BITS:0]        i_exit_factor,
    output logic                          o_valid,
    output logic [STEP_BITS-1:0]          o_ramp_up_end,
    output logic [STEP_BITS-1:0]          o_ramp_down_start,
    output logic [RATE_BITS-1:0]          o_entry_rate,
    output logic [RATE_BITS-1:0]          o_exit_rate
);
    import tpg_pkg::*;

    localparam int RB    = RATE_BITS;
    localparam int SB    = STEP_BITS;
    localparam int FB    = FRACTION_BITS;
    localparam int PS_W  = RB + FB + 1;      // rate times factor
    localparam int PR_W  = 2 * RB + 1;       // difference of squared rates
    localparam int DEN_W = ACCEL_W + 1;      // twice the acceleration
    localparam int CL_W  = (RB > MIN_W) ? RB : MIN_W;
    localparam int DL    = SB + 1;           // divider latency
    localparam logic [RB-1:0] RATE_MAX = '1;

    // Fields that ride alongside the dividers.
    typedef struct packed {
        logic          vld;
        logic          a_nz;
        logic          ge;
        logic [SB-1:0] t;
        logic [RB-1:0] s;
        logic [RB-1:0] e;
    } t_side;

    // Scale with ceiling, saturate to the rate range, then apply the minimum rate.
    function automatic logic [RB-1:0] f_scale(input logic [PS_W-1:0] p,
                                              input logic [MIN_W-1:0] mn);
        logic [PS_W:0]   sum;
        logic [RB+1:0]   r;
        logic [RB-1:0]   rc;
        logic [CL_W-1:0] mn_x;
        sum  = {1'b0, p} + (PS_W+1)'((64'd1 << FB) - 64'd1);
        r    = sum[PS_W:FB];
        rc   = (r > (RB+2)'(RATE_MAX)) ? RATE_MAX : r[RB-1:0];
        mn_x = CL_W'(mn);
        if (mn_x > CL_W'(rc)) begin
            rc = (mn_x > CL_W'(RATE_MAX)) ? RATE_MAX : mn_x[RB-1:0];
        end
        return rc;
    endfunction

    logic [MIN_W-1:0] r_min_rate;

    // Stage A: the two rate products.
    logic               r_a_vld;
    logic [RB-1:0]      r_a_n;
    logic [ACCEL_W-1:0] r_a_acc;
    logic [SB-1:0]      r_a_t;
    logic [PS_W-1:0]    r_a_pe;
    logic [PS_W-1:0]    r_a_px;

    // Stage B: start and end rates.
    logic               r_b_vld;
    logic [RB-1:0]      r_b_n;
    logic [ACCEL_W-1:0] r_b_acc;
    logic [SB-1:0]      r_b_t;
    logic [RB-1:0]      r_b_s;
    logic [RB-1:0]      r_b_e;

    // Stage C: differences of squares for both ramps and for the crossing point.
    t_side              r_c_side;
    logic [PR_W-1:0]    r_c_pu;
    logic [PR_W-1:0]    r_c_pd;
    logic [PR_W-1:0]    r_c_pq;
    logic [DEN_W-1:0]   r_c_den;

    logic [RB-1:0]      w_du;
    logic [RB-1:0]      w_dd;
    logic [RB-1:0]      w_dq;
    logic [RB:0]        w_su;
    logic [RB:0]        w_sd;
    logic [RB:0]        w_sq;
    logic               w_ge;

    t_side              r_side [0:DL-1];

    logic [SB:0]        w_quo_u;
    logic [SB:0]        w_quo_d;
    logic [SB:0]        w_quo_q;
    logic               w_rem_u;
    logic               w_rem_d;
    logic               w_rem_q;
    logic               w_unused_rem_d;

    t_side              w_fs;
    logic [SB:0]        w_up;
    logic [SB:0]        w_dn;
    logic               w_fit;
    logic [SB-1:0]      w_k;
    logic [SB-1:0]      w_diff;
    logic [SB:0]        w_mid;

    logic               r_vld;
    logic [SB-1:0]      r_up_end;
    logic [SB-1:0]      r_dn_start;
    logic [RB-1:0]      r_s;
    logic [RB-1:0]      r_e;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_rate <= MIN_RATE_RESET;
        end else if (i_cfg_we) begin
            r_min_rate <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            r_a_vld <= start && !busy;
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_n   <= i_nominal_rate;
        r_a_acc <= i_accel_rate;
        r_a_t   <= i_total_steps;
        r_a_pe  <= PS_W'(i_nominal_rate) * PS_W'(i_entry_factor);
        r_a_px  <= PS_W'(i_nominal_rate) * PS_W'(i_exit_factor);
        r_b_n   <= r_a_n;
        r_b_acc <= r_a_acc;
        r_b_t   <= r_a_t;
        r_b_s   <= f_scale(r_a_pe, r_min_rate);
        r_b_e   <= f_scale(r_a_px, r_min_rate);
    end

    // A rate at or above cruise gives a zero ramp, so its product is forced to zero.
    assign w_ge = r_b_e >= r_b_s;
    assign w_du = (r_b_n > r_b_s) ? r_b_n - r_b_s : '0;
    assign w_dd = (r_b_n > r_b_e) ? r_b_n - r_b_e : '0;
    assign w_dq = w_ge ? r_b_e - r_b_s : r_b_s - r_b_e;
    assign w_su = (RB+1)'(r_b_n) + (RB+1)'(r_b_s);
    assign w_sd = (RB+1)'(r_b_n) + (RB+1)'(r_b_e);
    assign w_sq = (RB+1)'(r_b_s) + (RB+1)'(r_b_e);

    // Only the valid bit is reset; the data fields simply follow stage B.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_side.vld <= 1'b0;
        end else begin
            r_c_side.vld <= r_b_vld;
        end
        r_c_side.a_nz <= r_b_acc != '0;
        r_c_side.ge   <= w_ge;
        r_c_side.t    <= r_b_t;
        r_c_side.s    <= r_b_s;
        r_c_side.e    <= r_b_e;
        r_c_pu        <= PR_W'(w_du) * PR_W'(w_su);
        r_c_pd        <= PR_W'(w_dd) * PR_W'(w_sd);
        r_c_pq        <= PR_W'(w_dq) * PR_W'(w_sq);
        r_c_den       <= {r_b_acc, 1'b0};
    end

    // Three dividers by twice the acceleration, all with saturated quotients.
    tpg_div #(.NUM_W(PR_W), .DEN_W(DEN_W), .QUO_W(SB)) u_div_up (
        .i_clk    (i_clk),
        .i_num    (r_c_pu),
        .i_den    (r_c_den),
        .o_quo    (w_quo_u),
        .o_rem_nz (w_rem_u)
    );

    tpg_div #(.NUM_W(PR_W), .DEN_W(DEN_W), .QUO_W(SB)) u_div_down (
        .i_clk    (i_clk),
        .i_num    (r_c_pd),
        .i_den    (r_c_den),
        .o_quo    (w_quo_d),
        .o_rem_nz (w_rem_d)
    );

    tpg_div #(.NUM_W(PR_W), .DEN_W(DEN_W), .QUO_W(SB)) u_div_cross (
        .i_clk    (i_clk),
        .i_num    (r_c_pq),
        .i_den    (r_c_den),
        .o_quo    (w_quo_q),
        .o_rem_nz (w_rem_q)
    );

    // The deceleration ramp rounds down, so its remainder is not needed.
    assign w_unused_rem_d = w_rem_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DL; i++) begin
                r_side[i] <= '0;
            end
        end else begin
            r_side[0] <= r_c_side;
            for (int i = 1; i < DL; i++) begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    assign w_fs = r_side[DL-1];

    // Acceleration ramp rounds up unless already saturated; zero acceleration gives no ramps.
    assign w_up = !w_fs.a_nz ? '0 :
                  (w_quo_u[SB] ? w_quo_u : w_quo_u + (SB+1)'(w_rem_u));
    assign w_dn = w_fs.a_nz ? w_quo_d : '0;
    assign w_fit = ((SB+2)'(w_up) + (SB+2)'(w_dn)) <= (SB+2)'(w_fs.t);

    // Crossing point when the two ramps overlap.
    assign w_mid  = (SB+1)'(w_fs.t) + w_quo_q;
    assign w_diff = w_fs.t - w_quo_q[SB-1:0];

    always_comb begin
        w_k = '0;
        if (w_fs.ge) begin
            if (w_quo_q >= (SB+1)'(w_fs.t)) begin
                w_k = w_fs.t;
            end else begin
                w_k = w_mid[SB:1];
            end
        end else if (w_quo_q < (SB+1)'(w_fs.t)) begin
            w_k = w_rem_q ? (w_diff - 1'b1) >> 1 : w_diff >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= w_fs.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_up_end   <= w_fit ? w_up[SB-1:0] : w_k;
        r_dn_start <= w_fit ? w_fs.t - w_dn[SB-1:0] : w_k;
        r_s        <= w_fs.s;
        r_e        <= w_fs.e;
    end

    assign o_valid           = r_vld;
    assign o_ramp_up_end     = r_up_end;
    assign o_ramp_down_start = r_dn_start;
    assign o_entry_rate      = r_s;
    assign o_exit_rate       = r_e;

endmodule

@@ hdl/tpg_div.sv @@
module tpg_div #(
    parameter int NUM_W = 41,
    parameter int DEN_W = tpg_pkg::ACCEL_W + 1,
    parameter int QUO_W = 20
) (
    input  logic             i_clk,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [QUO_W:0]   o_quo,
    output logic             o_rem_nz
);
    import tpg_pkg::*;

    // Pipelined restoring divider that yields one quotient bit per stage. A quotient
    // of 2^QUO_W or more saturates at 2^QUO_W.
    localparam int EXT_W = NUM_W + QUO_W;
    localparam int CMP_W = NUM_W + DEN_W + QUO_W;

    logic [EXT_W-1:0] w_ext;
    logic             w_sat;

    logic [DEN_W-1:0] r_rem [0:QUO_W];
    logic [QUO_W-1:0] r_q   [0:QUO_W];
    logic [QUO_W-1:0] r_low [0:QUO_W];
    logic [DEN_W-1:0] r_den [0:QUO_W];
    logic             r_sat [0:QUO_W];

    assign w_ext = {{QUO_W{1'b0}}, i_num};
    assign w_sat = CMP_W'(i_num) >= (CMP_W'(i_den) << QUO_W);

    // When the quotient does not saturate, the upper numerator bits are below the divisor.
    always_ff @(posedge i_clk) begin
        r_rem[0] <= w_ext[QUO_W +: DEN_W];
        r_q[0]   <= '0;
        r_low[0] <= w_ext[QUO_W-1:0];
        r_den[0] <= i_den;
        r_sat[0] <= w_sat;
    end

    for (genvar j = 1; j <= QUO_W; j++) begin : g_stage
        logic [DEN_W:0] w_trial;
        logic [DEN_W:0] w_diff;
        logic           w_ge;

        assign w_trial = {r_rem[j-1], r_low[j-1][QUO_W-j]};
        assign w_diff  = w_trial - {1'b0, r_den[j-1]};
        assign w_ge    = w_trial >= {1'b0, r_den[j-1]};

        always_ff @(posedge i_clk) begin
            r_rem[j] <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
            r_q[j]   <= {r_q[j-1][QUO_W-2:0], w_ge};
            r_low[j] <= r_low[j-1];
            r_den[j] <= r_den[j-1];
            r_sat[j] <= r_sat[j-1];
        end
    end

    assign o_quo    = r_sat[QUO_W] ? {1'b1, {QUO_W{1'b0}}} : {1'b0, r_q[QUO_W]};
    assign o_rem_nz = r_sat[QUO_W] || (r_rem[QUO_W] != '0);

endmodule

@@ hdl/tpg_checker.sv @@
module tpg_checker #(
    parameter int STEP_BITS = 20
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 o_valid,
    input logic [STEP_BITS-1:0] o_ramp_up_end,
    input logic [STEP_BITS-1:0] o_ramp_down_start
);

    localparam int LAT   = STEP_BITS + 5;
    localparam int CNT_W = $clog2(LAT + 2);

    logic [CNT_W-1:0] r_since;

    // Cycles since reset was released, saturating once the pipeline has filled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_since <= '0;
        end else if (r_since <= CNT_W'(LAT)) begin
            r_since <= r_since + 1'b1;
        end
    end

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy was raised");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n || r_since <= CNT_W'(LAT))
        o_valid == $past(start && !busy, LAT))
        else $error("result strobe does not match an accepted segment");

    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_since < CNT_W'(LAT)) |-> !o_valid)
        else $error("result strobe before the pipeline could fill");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_ramp_up_end <= o_ramp_down_start))
        else $error("acceleration ends after deceleration begins");

endmodule

bind trapezoid_profile_generator tpg_checker #(
    .STEP_BITS (STEP_BITS)
) u_tpg_checker (.*);
